// File: rtl/core/rkgm_pkg.sv
// Package for the rotary knob gesture mapper: event and action codes,
// configuration and result types, queue sizing. No dependencies.
package rkgm_pkg;

    localparam int EvWidth     = 3;
    localparam int ActWidth    = 4;
    localparam int TicksWidth  = 16;
    localparam int RunWidth    = 8;
    localparam int CfgIdxWidth = 2;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int QueueCntW   = $clog2(QueueDepth + 1);

    localparam logic [TicksWidth-1:0] DefaultPressTicks = TicksWidth'(350);
    localparam logic [RunWidth-1:0]   RunMax = {RunWidth{1'b1}};

    typedef enum logic [EvWidth-1:0] {
        EV_LEFT     = 3'd0,
        EV_RIGHT    = 3'd1,
        EV_PRESSED  = 3'd2,
        EV_RELEASED = 3'd3,
        EV_TICK     = 3'd4
    } event_t;

    typedef enum logic [ActWidth-1:0] {
        ACT_KNOB_LEFT  = 4'd0,
        ACT_KNOB_RIGHT = 4'd1,
        ACT_KNOB_PUSH  = 4'd2,
        ACT_PLAY       = 4'd3,
        ACT_PAUSE      = 4'd4,
        ACT_PREV       = 4'd5,
        ACT_NEXT       = 4'd6,
        ACT_VOLDOWN    = 4'd7,
        ACT_VOLUP      = 4'd8,
        ACT_TOGGLE     = 4'd9,
        ACT_NAV_LEFT   = 4'd10
    } action_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_RAW_MODE      = 2'd0,
        CFG_KNOB_ONLY     = 2'd1,
        CFG_VOL_HOLD      = 2'd2,
        CFG_PRESS_TICKS   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                  raw_mode;
        logic                  knob_only_mode;
        logic                  vol_hold;
        logic [TicksWidth-1:0] double_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic [ActWidth-1:0] action_code;
        logic                is_press;
        logic                last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } core_out_t;

endpackage

// File: rtl/core/rkgm_cfg.sv
// Configuration register file of the gesture mapper.
// Depends on rkgm_pkg.
module rkgm_cfg import rkgm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [TicksWidth-1:0]  cfg_data,
    output logic                   cfg_ready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_RAW_MODE:    cfg_next.raw_mode           = cfg_data[0];
                CFG_KNOB_ONLY:   cfg_next.knob_only_mode     = cfg_data[0];
                CFG_VOL_HOLD:    cfg_next.vol_hold           = cfg_data[0];
                CFG_PRESS_TICKS: cfg_next.double_press_ticks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.raw_mode           <= 1'b0;
            cfg_reg.knob_only_mode     <= 1'b0;
            cfg_reg.vol_hold           <= 1'b0;
            cfg_reg.double_press_ticks <= DefaultPressTicks;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/rkgm_core.sv
// Gesture state and decode: maps one event to up to two actions.
// Depends on rkgm_pkg.
module rkgm_core import rkgm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                fire,
    input  logic [EvWidth-1:0]  event_kind,
    input  logic                hold_press,
    output core_out_t           out
);

    logic                  nav_reg, nav_next;
    logic                  click_reg, click_next;
    logic [RunWidth-1:0]   run_reg, run_next;
    logic                  tact_reg, tact_next;
    logic [TicksWidth-1:0] trem_reg, trem_next;

    logic [TicksWidth-1:0] start_val;
    logic [1:0]            n;
    logic [ActWidth-1:0]   a0, a1;
    logic                  p0;

    assign start_val = (cfg.double_press_ticks == '0) ? TicksWidth'(1) : cfg.double_press_ticks;

    always_comb begin
        nav_next   = nav_reg;
        click_next = click_reg;
        run_next   = run_reg;
        tact_next  = tact_reg;
        trem_next  = trem_reg;
        n  = 2'd0;
        a0 = ACT_KNOB_LEFT;
        a1 = ACT_KNOB_LEFT;
        p0 = 1'b1;

        if (event_kind == EV_TICK) begin
            if (tact_reg) begin
                if (trem_reg > TicksWidth'(1)) begin
                    trem_next = trem_reg - TicksWidth'(1);
                end else begin
                    tact_next = 1'b0;
                    trem_next = '0;
                    if (click_reg) begin
                        n = 2'd1;
                        a0 = ACT_KNOB_PUSH;
                        click_next = 1'b0;
                    end else if (run_reg != '0) begin
                        if (run_reg == RunWidth'(1)) begin
                            n = 2'd1;
                            a0 = ACT_KNOB_LEFT;
                        end
                        run_next = '0;
                    end
                end
            end
        end else if (event_kind > EV_TICK) begin
            n = 2'd0;
        end else if (cfg.raw_mode) begin
            n = 2'd1;
            case (event_kind)
                EV_LEFT:  a0 = ACT_KNOB_LEFT;
                EV_RIGHT: a0 = ACT_KNOB_RIGHT;
                default: begin
                    a0 = ACT_KNOB_PUSH;
                    p0 = (event_kind == EV_PRESSED);
                end
            endcase
        end else if (cfg.knob_only_mode) begin
            case (event_kind)
                EV_LEFT: begin
                    if (run_reg != '0) begin
                        n = (run_reg == RunWidth'(1)) ? 2'd2 : 2'd1;
                        a0 = ACT_KNOB_LEFT;
                        a1 = ACT_KNOB_LEFT;
                    end
                    tact_next = 1'b1;
                    trem_next = start_val;
                    if (run_reg != RunMax) run_next = run_reg + RunWidth'(1);
                end
                EV_RIGHT: begin
                    n = 2'd1;
                    if (run_reg == RunWidth'(1)) begin
                        a0 = ACT_PAUSE;
                        run_next  = '0;
                        tact_next = 1'b0;
                        trem_next = '0;
                    end else begin
                        a0 = ACT_KNOB_RIGHT;
                    end
                end
                EV_PRESSED: begin
                    if (hold_press) begin
                        n = 2'd1;
                        a0 = ACT_PLAY;
                    end else if (click_reg) begin
                        n = 2'd1;
                        a0 = ACT_NAV_LEFT;
                        tact_next = 1'b0;
                        trem_next = '0;
                    end else begin
                        tact_next = 1'b1;
                        trem_next = start_val;
                    end
                    click_next = ~click_reg;
                end
                default: n = 2'd0;
            endcase
        end else begin
            case (event_kind)
                EV_LEFT: begin
                    n = 2'd1;
                    if (nav_reg)           a0 = ACT_PREV;
                    else if (cfg.vol_hold) a0 = ACT_VOLDOWN;
                    else                   a0 = ACT_KNOB_LEFT;
                end
                EV_RIGHT: begin
                    n = 2'd1;
                    if (nav_reg)           a0 = ACT_NEXT;
                    else if (cfg.vol_hold) a0 = ACT_VOLUP;
                    else                   a0 = ACT_KNOB_RIGHT;
                end
                EV_PRESSED: begin
                    if (hold_press) begin
                        nav_next = ~nav_reg;
                    end else begin
                        n = 2'd1;
                        a0 = cfg.vol_hold ? ACT_TOGGLE : ACT_KNOB_PUSH;
                    end
                end
                default: n = 2'd0;
            endcase
        end
    end

    assign out.count            = n;
    assign out.res0.action_code = a0;
    assign out.res0.is_press    = p0;
    assign out.res0.last_of_run = (n == 2'd1);
    assign out.res1.action_code = a1;
    assign out.res1.is_press    = 1'b1;
    assign out.res1.last_of_run = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nav_reg   <= 1'b0;
            click_reg <= 1'b0;
            run_reg   <= '0;
            tact_reg  <= 1'b0;
            trem_reg  <= '0;
        end else if (fire) begin
            nav_reg   <= nav_next;
            click_reg <= click_next;
            run_reg   <= run_next;
            tact_reg  <= tact_next;
            trem_reg  <= trem_next;
        end
    end

endmodule

// File: rtl/core/rkgm_queue.sv
// Result queue: takes up to two results a cycle, hands out one.
// Depends on rkgm_pkg.
module rkgm_queue import rkgm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  core_out_t            din,
    input  logic                 pop,
    output result_t              dout,
    output logic [QueueCntW-1:0] count
);

    result_t               mem_reg [QueueDepth];
    logic [QueuePtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QueueCntW-1:0]  cnt_reg, cnt_next;
    logic [1:0]            n_in;
    logic                  do_pop;

    assign n_in   = push ? din.count : 2'd0;
    assign do_pop = pop && (cnt_reg != '0);
    assign dout   = mem_reg[rd_ptr_reg];
    assign count  = cnt_reg;
    assign cnt_next = cnt_reg + QueueCntW'(n_in) - QueueCntW'(do_pop);

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) mem_reg[wr_ptr_reg] <= din.res0;
        if (n_in == 2'd2) mem_reg[wr_ptr_reg + QueuePtrW'(1)] <= din.res1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QueuePtrW'(n_in);
            rd_ptr_reg <= rd_ptr_reg + QueuePtrW'(do_pop);
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/core/rotary_knob_gesture_mapper_unit.sv
// Rotary knob gesture mapper, top level. Depends on rkgm_pkg, rkgm_cfg,
// rkgm_core and rkgm_queue.
// A request is registered at the input, then decoded and written into the result queue that feeds m_*.
// Throughput: one request per cycle while results drain at one per cycle and the queue
// has room for two more; a request giving two results occupies two queue entries (4-entry queue).
// Reset (aresetn low, synchronous) clears gesture state, timer and queue;
// registers return to defaults (period 350 ticks).
module rotary_knob_gesture_mapper_unit import rkgm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [2:0] event_kind
    input  logic                   s_tuser,   // [0] hold_press
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [3:0] action_code
    output logic                   m_tuser,   // [0] is_press
    output logic                   m_tlast,   // last_of_run
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [TicksWidth-1:0]  cfg_data
);

    cfg_t                 cfg;
    core_out_t            core_out;
    result_t              q_dout;
    logic [QueueCntW-1:0] q_count;

    logic               in_valid_reg;
    logic [EvWidth-1:0] in_event_reg;
    logic               in_long_reg;
    logic               q_room;
    logic               proc_fire;

    assign q_room    = (q_count <= QueueCntW'(QueueDepth - 2));
    assign proc_fire = in_valid_reg && q_room;
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_event_reg <= s_tdata[EvWidth-1:0];
            in_long_reg  <= s_tuser;
        end
    end

    rkgm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    rkgm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .fire       (proc_fire),
        .event_kind (in_event_reg),
        .hold_press (in_long_reg),
        .out        (core_out)
    );

    rkgm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (proc_fire),
        .din     (core_out),
        .pop     (m_tready),
        .dout    (q_dout),
        .count   (q_count)
    );

    assign m_tvalid = (q_count != '0);
    assign m_tdata  = {{(8 - ActWidth){1'b0}}, q_dout.action_code};
    assign m_tuser  = q_dout.is_press;
    assign m_tlast  = q_dout.last_of_run;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QueueCntW'(QueueDepth))
        else $error("result queue overflow");

    a_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && core_out.count != 2'd0) |=> m_tvalid)
        else $error("decoded result not presented");

    a_held_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !q_room) |=> (in_valid_reg && $stable(in_event_reg)))
        else $error("pending request lost while queue full");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("results present after reset");

endmodule

// File: bench/rkgm_action_checker.sv
`timescale 1ns / 100ps
// Action scoreboard for the rotary knob gesture mapper: follows register writes and
// accepted events, predicts the actions of each event and compares them in order.
// Depends on rkgm_pkg.
module rkgm_action_checker import rkgm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [7:0]             m_tdata,
    input  logic                   m_tuser,
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [TicksWidth-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    cfg_t                  settings;
    logic                  nav_toggle;
    logic                  click_wait;
    logic                  timer_on;
    logic [RunWidth-1:0]   left_run;
    logic [TicksWidth-1:0] timer_left;
    result_t               expected_actions[$];
    result_t               step_actions[$];
    int                    errors = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void note(input action_t code, input logic press);
        result_t r;
        r.action_code = code;
        r.is_press    = press;
        r.last_of_run = 1'b0;
        step_actions.push_back(r);
    endfunction

    function automatic void arm_timer();
        timer_on   = 1'b1;
        timer_left = (settings.double_press_ticks == '0) ? TicksWidth'(1)
                                                         : settings.double_press_ticks;
    endfunction

    function automatic void map_event(input logic [EvWidth-1:0] kind, input logic lp);
        result_t tail;
        step_actions.delete();
        if (kind == EV_TICK) begin
            if (timer_on) begin
                if (timer_left > 1) begin
                    timer_left = timer_left - 1'b1;
                end else begin
                    timer_on   = 1'b0;
                    timer_left = '0;
                    if (click_wait) begin
                        note(ACT_KNOB_PUSH, 1'b1);
                        click_wait = 1'b0;
                    end else if (left_run != '0) begin
                        if (left_run == 1) note(ACT_KNOB_LEFT, 1'b1);
                        left_run = '0;
                    end
                end
            end
        end else if (kind > EV_TICK) begin
            // undefined kinds are dropped
        end else if (settings.raw_mode) begin
            if (kind == EV_LEFT) note(ACT_KNOB_LEFT, 1'b1);
            else if (kind == EV_RIGHT) note(ACT_KNOB_RIGHT, 1'b1);
            else note(ACT_KNOB_PUSH, kind == EV_PRESSED);
        end else if (settings.knob_only_mode) begin
            if (kind == EV_LEFT) begin
                if (left_run != '0) begin
                    if (left_run == 1) note(ACT_KNOB_LEFT, 1'b1);
                    note(ACT_KNOB_LEFT, 1'b1);
                end
                arm_timer();
                if (left_run != RunMax) left_run = left_run + 1'b1;
            end else if (kind == EV_RIGHT) begin
                if (left_run == 1) begin
                    note(ACT_PAUSE, 1'b1);
                    left_run   = '0;
                    timer_on   = 1'b0;
                    timer_left = '0;
                end else begin
                    note(ACT_KNOB_RIGHT, 1'b1);
                end
            end else if (kind == EV_PRESSED) begin
                if (lp) begin
                    note(ACT_PLAY, 1'b1);
                end else if (click_wait) begin
                    note(ACT_NAV_LEFT, 1'b1);
                    timer_on   = 1'b0;
                    timer_left = '0;
                end else begin
                    arm_timer();
                end
                click_wait = ~click_wait;
            end
        end else begin
            if (kind == EV_LEFT) begin
                if (nav_toggle) note(ACT_PREV, 1'b1);
                else if (settings.vol_hold) note(ACT_VOLDOWN, 1'b1);
                else note(ACT_KNOB_LEFT, 1'b1);
            end else if (kind == EV_RIGHT) begin
                if (nav_toggle) note(ACT_NEXT, 1'b1);
                else if (settings.vol_hold) note(ACT_VOLUP, 1'b1);
                else note(ACT_KNOB_RIGHT, 1'b1);
            end else if (kind == EV_PRESSED) begin
                if (lp) nav_toggle = ~nav_toggle;
                else if (settings.vol_hold) note(ACT_TOGGLE, 1'b1);
                else note(ACT_KNOB_PUSH, 1'b1);
            end
        end
        if (step_actions.size() > 0) begin
            tail = step_actions.pop_back();
            tail.last_of_run = 1'b1;
            step_actions.push_back(tail);
        end
        foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            settings.raw_mode           = 1'b0;
            settings.knob_only_mode     = 1'b0;
            settings.vol_hold           = 1'b0;
            settings.double_press_ticks = DefaultPressTicks;
            nav_toggle = 1'b0;
            click_wait = 1'b0;
            timer_on   = 1'b0;
            left_run   = '0;
            timer_left = '0;
            expected_actions.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RAW_MODE:    settings.raw_mode           = cfg_data[0];
                    CFG_KNOB_ONLY:   settings.knob_only_mode     = cfg_data[0];
                    CFG_VOL_HOLD:    settings.vol_hold           = cfg_data[0];
                    CFG_PRESS_TICKS: settings.double_press_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.action_code = m_tdata[ActWidth-1:0];
                got.is_press    = m_tuser;
                got.last_of_run = m_tlast;
                if (expected_actions.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected action %0d press %b last %b", $time,
                                 got.action_code, got.is_press, got.last_of_run);
                end else begin
                    want = expected_actions.pop_front();
                    if (got.action_code != want.action_code || got.is_press != want.is_press ||
                        got.last_of_run != want.last_of_run) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: action exp %0d got %0d, press exp %b got %b,",
                                      " last exp %b got %b"},
                                     $time, want.action_code, got.action_code, want.is_press,
                                     got.is_press, want.last_of_run, got.last_of_run);
                    end
                end
            end
            if (s_tvalid && s_tready) map_event(s_tdata[EvWidth-1:0], s_tuser);
        end
        fail_count <= errors;
        pending    <= expected_actions.size();
    end

endmodule

// File: bench/rotary_knob_gesture_mapper_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for rotary_knob_gesture_mapper_unit: drives events, register writes and
// output backpressure, and gives the verdict.
// Depends on rkgm_pkg, the block and rkgm_action_checker.
module rotary_knob_gesture_mapper_unit_tb;
    import rkgm_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [TicksWidth-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending;

    int                     event_count = 0;
    int                     press_period = 350;
    bit                     steady = 1'b0;

    rotary_knob_gesture_mapper_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    rkgm_action_checker action_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // output backpressure: mostly short ready runs, some long ones
    initial begin
        int run_len;
        int stall_len;
        forever begin
            run_len = $urandom_range(0, 99);
            if (run_len < 70) run_len = $urandom_range(1, 4);
            else if (run_len < 95) run_len = $urandom_range(5, 20);
            else run_len = $urandom_range(50, 150);
            stall_len = $urandom_range(0, 99);
            if (stall_len < 50) stall_len = 0;
            else if (stall_len < 90) stall_len = $urandom_range(1, 3);
            else stall_len = $urandom_range(8, 40);
            @(posedge aclk);
            m_tready <= 1'b1;
            repeat (run_len - 1) @(posedge aclk);
            if (stall_len > 0) begin
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge aclk);
            end
        end
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [EvWidth-1:0] random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return EV_LEFT;
        if (r < 50) return EV_RIGHT;
        if (r < 70) return EV_PRESSED;
        if (r < 85) return EV_RELEASED;
        if (r < 95) return EV_TICK;
        return EvWidth'($urandom_range(EV_TICK + 1, 7));
    endfunction

    task automatic send_event(input logic [EvWidth-1:0] kind, input logic lp);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(8 - EvWidth){1'b0}}, kind};
        s_tuser  <= lp;
        do @(posedge aclk); while (!s_tready);
        event_count++;
        gap = steady ? 0 : random_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_event(EV_TICK, 1'($urandom_range(0, 1)));
    endtask

    // ticks that run the double-press timer out, or a few if the period is long
    task automatic expire_timer();
        int per;
        per = (press_period == 0) ? 1 : press_period;
        if (per <= 16) send_ticks(per + $urandom_range(0, 1));
        else send_ticks($urandom_range(1, 8));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [TicksWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic raw, input logic knob, input logic vol,
                                  input logic [TicksWidth-1:0] ticks);
        wait_drained();
        write_reg(CFG_RAW_MODE, TicksWidth'(raw));
        write_reg(CFG_KNOB_ONLY, TicksWidth'(knob));
        write_reg(CFG_VOL_HOLD, TicksWidth'(vol));
        write_reg(CFG_PRESS_TICKS, ticks);
        cfg_valid <= 1'b0;
        press_period = int'(ticks);
    endtask

    task automatic knob_gesture();
        int g;
        g = $urandom_range(0, 9);
        case (g)
            0, 1: begin
                send_event(EV_PRESSED, 1'b0);
                expire_timer();
            end
            2: begin
                send_event(EV_PRESSED, 1'b0);
                send_ticks($urandom_range(0, (press_period > 3) ? 2 : 0));
                send_event(EV_PRESSED, 1'b0);
            end
            3: begin
                send_event(EV_LEFT, 1'($urandom_range(0, 1)));
                send_event(EV_RIGHT, 1'($urandom_range(0, 1)));
            end
            4: begin
                repeat ($urandom_range(1, 5)) send_event(EV_LEFT, 1'($urandom_range(0, 1)));
                expire_timer();
            end
            5: send_event(EV_PRESSED, 1'b1);
            6: send_event(EV_RIGHT, 1'($urandom_range(0, 1)));
            7: send_ticks($urandom_range(1, 6));
            default: send_event(random_kind(), 1'($urandom_range(0, 1)));
        endcase
    endtask

    initial begin
        int r;
        int batch;
        logic raw;
        logic knob;
        logic [TicksWidth-1:0] ticks;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // normal mode, defaults from reset
        send_event(EV_LEFT, 1'b0);
        send_event(EV_RIGHT, 1'b0);
        send_event(EV_PRESSED, 1'b0);
        send_event(EV_RELEASED, 1'b0);
        send_event(EV_PRESSED, 1'b1);
        send_event(EV_LEFT, 1'b0);
        send_event(EV_RIGHT, 1'b1);
        send_event(EV_PRESSED, 1'b1);
        send_event(EV_TICK, 1'b0);
        for (int k = EV_TICK + 1; k < 8; k++) send_event(EvWidth'(k), 1'b1);

        apply_settings(1'b0, 1'b0, 1'b1, 16'd350);
        send_event(EV_LEFT, 1'b0);
        send_event(EV_RIGHT, 1'b0);
        send_event(EV_PRESSED, 1'b0);

        // raw mode wins over the other modes
        apply_settings(1'b1, 1'b1, 1'b1, 16'd1);
        send_event(EV_LEFT, 1'b0);
        send_event(EV_RIGHT, 1'b0);
        send_event(EV_PRESSED, 1'b0);
        send_event(EV_RELEASED, 1'b1);

        // knob-only, zero period acts as one tick
        apply_settings(1'b0, 1'b1, 1'b0, 16'd0);
        send_event(EV_PRESSED, 1'b0);
        send_event(EV_TICK, 1'b0);
        send_event(EV_PRESSED, 1'b0);
        send_event(EV_PRESSED, 1'b0);
        send_event(EV_LEFT, 1'b0);
        send_event(EV_TICK, 1'b0);
        send_event(EV_LEFT, 1'b0);
        send_event(EV_RIGHT, 1'b0);
        send_event(EV_LEFT, 1'b0);
        send_event(EV_LEFT, 1'b0);
        send_event(EV_PRESSED, 1'b1);

        // left run past saturation with the longest period
        apply_settings(1'b0, 1'b1, 1'b0, 16'hFFFF);
        steady = 1'b1;
        repeat ($urandom_range(262, 275)) send_event(EV_LEFT, 1'($urandom_range(0, 1)));
        steady = 1'b0;
        send_event(EV_RIGHT, 1'b0);

        while (event_count < 600) begin
            r = $urandom_range(0, 99);
            raw  = (r < 15);
            knob = raw ? 1'($urandom_range(0, 1)) : (r < 70);
            r = $urandom_range(0, 99);
            if (r < 40) ticks = TicksWidth'($urandom_range(1, 4));
            else if (r < 65) ticks = TicksWidth'($urandom_range(5, 12));
            else if (r < 75) ticks = '0;
            else if (r < 85) ticks = 16'hFFFF;
            else ticks = TicksWidth'($urandom_range(0, 16'hFFFF));
            apply_settings(raw, knob, 1'($urandom_range(0, 1)), ticks);
            steady = ($urandom_range(0, 3) == 0);
            batch = $urandom_range(20, 60);
            for (int i = 0; i < batch && event_count < 600; i++) begin
                if (knob && !raw) knob_gesture();
                else send_event(random_kind(), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 39) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
